>>> src/esws_pkg.sv
// shared constants and types for the exchange sort block with statistics
package esws_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_W     = 32;
  localparam int SUM_W      = 36;
  localparam int RANK_W     = 4;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 136;

  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PRIME,
    ST_SCAN,
    ST_WBACK,
    ST_EREAD,
    ST_EOUT
  } state_e;

endpackage

>>> src/esws_ram.sv
// generic single write port ram with one registered read port
module esws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/exchange_sort_with_stats.sv
// top level: collects a set of values, sorts it in place and streams it out with statistics
//
// Usage: values enter on the s_axis channel, one per transaction, with tlast on the
// last value of a set. Up to CAPACITY values are stored in a small ram; further
// values are dropped and the overflow flag is raised for the set. When the set
// closes, tready falls and an exchange sort runs on a single comparator with one
// ram read and at most one write per cycle. The sorted values then leave on
// m_axis in ascending order, the next one read from the ram only once the current
// one has been taken, each carrying its rank, the set's maximum, minimum and 36-bit
// sum; tlast marks the last one. tready on the input stays low until the last
// result has been taken. A stalled receiver simply holds the current result, which
// stays stable. After reset the block is empty and ready; no store clearing is
// needed since only entries written in the current set are ever read.
module exchange_sort_with_stats (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [esws_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [31:0] sample
  input  logic                                s_axis_tlast,   // final_item
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] sorted_value, [35:32] rank, [67:36] largest, [99:68] smallest, [135:100] total
  output logic [esws_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,   // run_end
  output logic                                m_axis_tuser    // overflow
);

  esws_pkg::state_e state_q, state_d;

  logic        [esws_pkg::CNT_W-1:0]  fill_q;
  logic        [esws_pkg::CNT_W-1:0]  i_q;
  logic        [esws_pkg::CNT_W-1:0]  j_q;
  logic        [esws_pkg::CNT_W-1:0]  k_q;
  logic signed [esws_pkg::DATA_W-1:0] cur_q;
  logic signed [esws_pkg::DATA_W-1:0] max_q;
  logic signed [esws_pkg::DATA_W-1:0] min_q;
  logic signed [esws_pkg::SUM_W-1:0]  sum_q;
  logic                               dropped_q;

  logic                               ram_we;
  logic        [esws_pkg::IDX_W-1:0]  ram_waddr;
  logic        [esws_pkg::DATA_W-1:0] ram_wdata;
  logic        [esws_pkg::IDX_W-1:0]  ram_raddr;
  logic        [esws_pkg::DATA_W-1:0] ram_rdata;

  logic signed [esws_pkg::DATA_W-1:0] sample;
  logic signed [esws_pkg::DATA_W-1:0] rd_val;
  logic                               in_fire;
  logic                               out_fire;
  logic                               has_room;
  logic                               swap;
  logic                               scan_end;
  logic                               more_rows;
  logic                               emit_end;

  assign sample    = $signed(s_axis_tdata[esws_pkg::DATA_W-1:0]);
  assign rd_val    = $signed(ram_rdata);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_fire  = m_axis_tvalid && m_axis_tready;
  assign has_room  = fill_q < esws_pkg::CNT_W'(esws_pkg::CAPACITY);
  assign swap      = cur_q > rd_val;
  assign scan_end  = esws_pkg::CNT_W'(j_q + 1'b1) == fill_q;
  assign more_rows = ({1'b0, i_q} + (esws_pkg::CNT_W+1)'(2)) < {1'b0, fill_q};
  assign emit_end  = esws_pkg::CNT_W'(k_q + 1'b1) == fill_q;

  esws_ram #(
    .WIDTH (esws_pkg::DATA_W),
    .DEPTH (esws_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      esws_pkg::ST_IDLE: begin
        if (in_fire && s_axis_tlast) begin
          state_d = (fill_q != '0) ? esws_pkg::ST_FETCH : esws_pkg::ST_EREAD;
        end
      end
      esws_pkg::ST_FETCH: state_d = esws_pkg::ST_PRIME;
      esws_pkg::ST_PRIME: state_d = esws_pkg::ST_SCAN;
      esws_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = esws_pkg::ST_WBACK;
        end
      end
      esws_pkg::ST_WBACK: state_d = more_rows ? esws_pkg::ST_FETCH : esws_pkg::ST_EREAD;
      esws_pkg::ST_EREAD: state_d = esws_pkg::ST_EOUT;
      esws_pkg::ST_EOUT: begin
        if (out_fire) begin
          state_d = emit_end ? esws_pkg::ST_IDLE : esws_pkg::ST_EREAD;
        end
      end
      default: state_d = esws_pkg::ST_IDLE;
    endcase
  end

  // outputs and ram control
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = fill_q[esws_pkg::IDX_W-1:0];
    ram_wdata     = sample;
    ram_raddr     = k_q[esws_pkg::IDX_W-1:0];
    unique case (state_q)
      esws_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = s_axis_tvalid && has_room;
      end
      esws_pkg::ST_FETCH: ram_raddr = i_q[esws_pkg::IDX_W-1:0];
      esws_pkg::ST_PRIME: ram_raddr = j_q[esws_pkg::IDX_W-1:0];
      esws_pkg::ST_SCAN: begin
        ram_raddr = esws_pkg::IDX_W'(j_q + 1'b1);
        ram_we    = swap;
        ram_waddr = j_q[esws_pkg::IDX_W-1:0];
        ram_wdata = cur_q;
      end
      esws_pkg::ST_WBACK: begin
        ram_we    = 1'b1;
        ram_waddr = i_q[esws_pkg::IDX_W-1:0];
        ram_wdata = cur_q;
      end
      esws_pkg::ST_EREAD: ram_raddr = k_q[esws_pkg::IDX_W-1:0];
      esws_pkg::ST_EOUT:  m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata = {sum_q, min_q, max_q, esws_pkg::RANK_W'(k_q), ram_rdata};
  assign m_axis_tlast = emit_end;
  assign m_axis_tuser = dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= esws_pkg::ST_IDLE;
      fill_q    <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      max_q     <= esws_pkg::MOST_NEG;
      min_q     <= esws_pkg::MOST_POS;
      sum_q     <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        esws_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (has_room) begin
              fill_q <= fill_q + 1'b1;
              if (sample > max_q) begin
                max_q <= sample;
              end
              if (sample < min_q) begin
                min_q <= sample;
              end
              sum_q <= sum_q + esws_pkg::SUM_W'(sample);
            end else begin
              dropped_q <= 1'b1;
            end
            i_q <= '0;
            j_q <= esws_pkg::CNT_W'(1);
            k_q <= '0;
          end
        end
        esws_pkg::ST_SCAN: begin
          if (!scan_end) begin
            j_q <= j_q + 1'b1;
          end
        end
        esws_pkg::ST_WBACK: begin
          i_q <= i_q + 1'b1;
          j_q <= esws_pkg::CNT_W'(i_q + esws_pkg::CNT_W'(2));
        end
        esws_pkg::ST_EOUT: begin
          if (out_fire) begin
            k_q <= k_q + 1'b1;
            if (emit_end) begin
              fill_q    <= '0;
              max_q     <= esws_pkg::MOST_NEG;
              min_q     <= esws_pkg::MOST_POS;
              sum_q     <= '0;
              dropped_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working value of the current row
  always_ff @(posedge clk_i) begin
    if (state_q == esws_pkg::ST_PRIME || (state_q == esws_pkg::ST_SCAN && swap)) begin
      cur_q <= rd_val;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while a result is pending");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= esws_pkg::CNT_W'(esws_pkg::CAPACITY))
    else $error("fill count beyond capacity");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |-> fill_q == esws_pkg::CNT_W'(esws_pkg::CAPACITY))
    else $error("drop flagged while store not full");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> k_q < fill_q)
    else $error("result rank beyond stored count");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast) |=> (s_axis_tready && fill_q == '0 && !dropped_q))
    else $error("set not cleared after last result");

endmodule
